### hdl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// shared types, codes and reset values for the single-wire bus master
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int BitsPerByteDef = 8;
  localparam int AddrW          = 5;
  localparam int DataW          = 32;

  // input function codes
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncReset = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;
  localparam logic [1:0] FuncRead  = 2'd3;

  // register indexes
  localparam logic [2:0] RegIdleHigh  = 3'd0;
  localparam logic [2:0] RegResetLow  = 3'd1;
  localparam logic [2:0] RegResetWait = 3'd2;
  localparam logic [2:0] RegSlot      = 3'd3;
  localparam logic [2:0] RegLeadLow   = 3'd4;
  localparam logic [2:0] RegSampleDly = 3'd5;

  localparam logic [7:0] IdleHighRst  = 8'd15;
  localparam logic [9:0] ResetLowRst  = 10'd750;
  localparam logic [9:0] ResetWaitRst = 10'd470;
  localparam logic [7:0] SlotRst      = 8'd60;
  localparam logic [3:0] LeadLowRst   = 4'd1;
  localparam logic [3:0] SampleDlyRst = 4'd1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } res_t;

  typedef struct packed {
    logic [7:0] idle_high_ticks;
    logic [9:0] reset_low_ticks;
    logic [9:0] reset_wait_ticks;
    logic [7:0] slot_ticks;
    logic [3:0] lead_low_ticks;
    logic [3:0] sample_delay_ticks;
  } cfg_t;

endpackage

### hdl/one_wire_bus_master.sv
// path: an accepted word is held in the input register, then registered in the result register
// throughput: one word per cycle while the output is not stalled, set by the single-pass phase sequencer
// the input stall follows the output stall within the same cycle
// reset: line released, sequencer idle, timing registers at default values
// ----------------------------------------------------------------------------
// one_wire_bus_master
// open-drain single-wire bus master stepped by tick and command words
// ----------------------------------------------------------------------------
module one_wire_bus_master import owm_pkg::*; #(
  parameter int BitsPerByte = BitsPerByteDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  item_t            in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  logic  in_valid_q;
  item_t in_q;
  logic  adv;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_q       <= '0;
    end else if (!in_valid_q || adv) begin
      in_valid_q <= in_valid_i;
      in_q       <= in_data_i;
    end
  end

  owm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_core #(
    .BitsPerByte (BitsPerByte)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .vld_i       (in_valid_q),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o)
  );

endmodule

### hdl/owm_regs.sv
// ----------------------------------------------------------------------------
// owm_regs
// apb timing registers of the single-wire bus master
// ----------------------------------------------------------------------------
module owm_regs import owm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_high_ticks    <= IdleHighRst;
      cfg_q.reset_low_ticks    <= ResetLowRst;
      cfg_q.reset_wait_ticks   <= ResetWaitRst;
      cfg_q.slot_ticks         <= SlotRst;
      cfg_q.lead_low_ticks     <= LeadLowRst;
      cfg_q.sample_delay_ticks <= SampleDlyRst;
    end else if (wr_en) begin
      case (idx)
        RegIdleHigh:  cfg_q.idle_high_ticks    <= pwdata[7:0];
        RegResetLow:  cfg_q.reset_low_ticks    <= pwdata[9:0];
        RegResetWait: cfg_q.reset_wait_ticks   <= pwdata[9:0];
        RegSlot:      cfg_q.slot_ticks         <= pwdata[7:0];
        RegLeadLow:   cfg_q.lead_low_ticks     <= pwdata[3:0];
        RegSampleDly: cfg_q.sample_delay_ticks <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegIdleHigh:  prdata = {24'd0, cfg_q.idle_high_ticks};
      RegResetLow:  prdata = {22'd0, cfg_q.reset_low_ticks};
      RegResetWait: prdata = {22'd0, cfg_q.reset_wait_ticks};
      RegSlot:      prdata = {24'd0, cfg_q.slot_ticks};
      RegLeadLow:   prdata = {28'd0, cfg_q.lead_low_ticks};
      RegSampleDly: prdata = {28'd0, cfg_q.sample_delay_ticks};
      default:      prdata = '0;
    endcase
  end

endmodule

### hdl/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core
// bus phase sequencer with tick counter, bit shifter and result register
// ----------------------------------------------------------------------------
module owm_core import owm_pkg::*; #(
  parameter int BitsPerByte = BitsPerByteDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  vld_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  out_valid_o,
  output res_t  out_o
);

  localparam int BW = $clog2(BitsPerByte + 1);
  localparam logic [BW-1:0] NBits = BW'(BitsPerByte);

  typedef enum logic [2:0] {
    PhIdle, PhRstHigh, PhRstLow, PhRstWait, PhLead, PhWSlot, PhRDelay, PhRSlot
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [9:0]    cnt_q, cnt_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [7:0]    shift_q, shift_d;
  logic [7:0]    last_q, last_d;
  logic [1:0]    op_q, op_d;
  logic          out_valid_q;
  res_t          out_q;
  logic          entered;
  logic [BW-1:0] rem;
  logic [7:0]    fill;
  logic          proc;

  function automatic logic [9:0] phase_len(phase_e ph, cfg_t c);
    case (ph)
      PhRstHigh: phase_len = {2'd0, c.idle_high_ticks};
      PhRstLow:  phase_len = c.reset_low_ticks;
      PhRstWait: phase_len = c.reset_wait_ticks;
      PhLead:    phase_len = {6'd0, c.lead_low_ticks};
      PhWSlot:   phase_len = {2'd0, c.slot_ticks};
      PhRDelay:  phase_len = {6'd0, c.sample_delay_ticks};
      PhRSlot:   phase_len = {2'd0, c.slot_ticks};
      default:   phase_len = 10'd1;
    endcase
  endfunction

  assign proc = vld_i & adv_i;

  always_comb begin
    int sum;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    last_d  = last_q;
    op_d    = op_q;
    entered = 1'b0;
    rem     = '0;
    fill    = '0;
    sum     = 0;
    if (item_i.func != FuncTick) begin
      if (phase_q == PhIdle) begin
        op_d    = item_i.func;
        bit_d   = '0;
        entered = 1'b1;
        if (item_i.func == FuncReset) begin
          phase_d = PhRstHigh;
        end else begin
          shift_d = (item_i.func == FuncWrite) ? item_i.data_byte : 8'd0;
          phase_d = PhLead;
        end
      end
    end else if (phase_q != PhIdle) begin
      cnt_d = (cnt_q == 10'h3FF) ? cnt_q : cnt_q + 10'd1;
      if (cnt_d >= phase_len(phase_q, cfg_i)) begin
        entered = 1'b1;
        case (phase_q)
          PhRstHigh: phase_d = PhRstLow;
          PhRstLow:  phase_d = PhRstWait;
          PhLead:    phase_d = (op_q == FuncWrite) ? PhWSlot : PhRDelay;
          PhWSlot: begin
            shift_d = shift_d >> 1;
            bit_d   = bit_d + 1'b1;
            phase_d = (bit_d >= NBits) ? PhIdle : PhLead;
          end
          PhRDelay: begin
            shift_d = {item_i.line_level, shift_d[7:1]};
            phase_d = PhRSlot;
          end
          PhRSlot: begin
            bit_d = bit_d + 1'b1;
            if (bit_d >= NBits) begin
              last_d  = shift_d;
              phase_d = PhIdle;
            end else begin
              phase_d = PhLead;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end

    // pass through phases of zero length
    if (entered) begin
      cnt_d = '0;
      if (phase_d == PhRstHigh && cfg_i.idle_high_ticks == '0) phase_d = PhRstLow;
      if (phase_d == PhRstLow && cfg_i.reset_low_ticks == '0) phase_d = PhRstWait;
      if (phase_d == PhRstWait && cfg_i.reset_wait_ticks == '0) phase_d = PhIdle;
      if (phase_d == PhRSlot && cfg_i.slot_ticks == '0) begin
        bit_d = bit_d + 1'b1;
        if (bit_d >= NBits) begin
          last_d  = shift_d;
          phase_d = PhIdle;
        end else begin
          phase_d = PhLead;
        end
      end
      if (phase_d == PhWSlot && cfg_i.slot_ticks == '0) begin
        shift_d = shift_d >> 1;
        bit_d   = bit_d + 1'b1;
        phase_d = (bit_d >= NBits) ? PhIdle : PhLead;
      end
      if (phase_d == PhLead && cfg_i.lead_low_ticks == '0) begin
        phase_d = (op_d == FuncWrite) ? PhWSlot : PhRDelay;
      end
      // every write phase is empty: remaining bits go out at once
      if (phase_d == PhWSlot && cfg_i.slot_ticks == '0) begin
        phase_d = PhIdle;
      end
      if (phase_d == PhRDelay && cfg_i.sample_delay_ticks == '0) begin
        shift_d = {item_i.line_level, shift_d[7:1]};
        phase_d = PhRSlot;
      end
      if (phase_d == PhRSlot && cfg_i.slot_ticks == '0) begin
        bit_d = bit_d + 1'b1;
        if (bit_d >= NBits) begin
          last_d  = shift_d;
          phase_d = PhIdle;
        end else begin
          phase_d = PhLead;
        end
      end
      // every read phase is empty: remaining bits all sample the same level
      if (phase_d == PhLead && cfg_i.lead_low_ticks == '0) begin
        rem = NBits - bit_d;
        for (int j = 0; j < 8; j++) begin
          sum = j + int'(rem);
          if (sum >= 8) begin
            fill[j] = item_i.line_level;
          end else begin
            fill[j] = shift_d[sum[2:0]];
          end
        end
        shift_d = fill;
        last_d  = fill;
        bit_d   = NBits;
        phase_d = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cnt_q       <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      last_q      <= '0;
      op_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (adv_i) begin
      out_valid_q <= vld_i;
      if (vld_i) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        last_q  <= last_d;
        op_q    <= op_d;
        out_q.drive_low <= (phase_d == PhRstLow) || (phase_d == PhLead) ||
                           ((phase_d == PhWSlot) && !shift_d[0]);
        out_q.busy_res  <= (phase_d != PhIdle);
        out_q.done_res  <= entered && (phase_d == PhIdle);
        out_q.read_byte <= last_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done reported while still busy");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.busy_res |-> !out_q.drive_low)
    else $error("line pulled low while idle");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhIdle |-> bit_q < NBits)
    else $error("bit index out of range during operation");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(phase_q) && $stable(last_q) && $stable(cnt_q))
    else $error("state moved without an item");

endmodule

### tb/sv/one_wire_bus_master_checker.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// watches the word channels and the register port of the single-wire master,
// steps its own copy of the phase sequencer on every accepted input word and
// compares every accepted result word against the oldest predicted one
// ----------------------------------------------------------------------------
module one_wire_bus_master_checker import owm_pkg::*; #(
  parameter int BitsPerByte = BitsPerByteDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  item_t            in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  res_t             out_data_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               mismatches_o,
  output int               pending_o,
  output logic             busy_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhIdle, PhRstHigh, PhRstLow, PhRstWait, PhLead, PhWSlot, PhRDelay, PhRSlot
  } phase_e;

  cfg_t       timing;
  phase_e     ph;
  logic [9:0] tick_cnt;
  int         bit_idx;
  logic [7:0] shreg;
  logic       drv;
  logic [1:0] op;
  logic [7:0] last_rd;
  logic       done;

  res_t       expected_words[$];
  res_t       want;
  logic       bad;

  assign busy_o = (ph != PhIdle);

  function automatic logic [9:0] span(phase_e p);
    case (p)
      PhRstHigh: return 10'(timing.idle_high_ticks);
      PhRstLow:  return timing.reset_low_ticks;
      PhRstWait: return timing.reset_wait_ticks;
      PhLead:    return 10'(timing.lead_low_ticks);
      PhWSlot:   return 10'(timing.slot_ticks);
      PhRDelay:  return 10'(timing.sample_delay_ticks);
      PhRSlot:   return 10'(timing.slot_ticks);
      default:   return 10'd1;
    endcase
  endfunction

  function automatic void set_ph(phase_e p);
    ph       = p;
    tick_cnt = '0;
    case (p)
      PhRstLow, PhLead: drv = 1'b1;
      PhWSlot:          drv = ~shreg[0];
      default:          drv = 1'b0;
    endcase
    if (p == PhIdle) done = 1'b1;
  endfunction

  function automatic phase_e following(logic line);
    case (ph)
      PhRstHigh: return PhRstLow;
      PhRstLow:  return PhRstWait;
      PhLead:    return (op == FuncWrite) ? PhWSlot : PhRDelay;
      PhWSlot: begin
        shreg = shreg >> 1;
        bit_idx++;
        return (bit_idx >= BitsPerByte) ? PhIdle : PhLead;
      end
      PhRDelay: begin
        shreg = {line, shreg[7:1]};
        return PhRSlot;
      end
      PhRSlot: begin
        bit_idx++;
        if (bit_idx >= BitsPerByte) begin
          last_rd = shreg;
          return PhIdle;
        end
        return PhLead;
      end
      default: return PhIdle;
    endcase
  endfunction

  // zero-length phases are passed straight through
  function automatic void settle(phase_e p, logic line);
    set_ph(p);
    while (ph != PhIdle && span(ph) == 10'd0) set_ph(following(line));
  endfunction

  function automatic res_t predict_bus(item_t w);
    res_t r;
    done = 1'b0;
    if (w.func != FuncTick) begin
      if (ph == PhIdle) begin
        op      = w.func;
        bit_idx = 0;
        if (w.func == FuncReset) begin
          settle(PhRstHigh, w.line_level);
        end else begin
          shreg = (w.func == FuncWrite) ? w.data_byte : 8'h00;
          settle(PhLead, w.line_level);
        end
      end
    end else if (ph != PhIdle) begin
      if (tick_cnt != 10'h3ff) tick_cnt++;
      if (tick_cnt >= span(ph)) settle(following(w.line_level), w.line_level);
    end
    r.drive_low = drv;
    r.busy_res  = (ph != PhIdle);
    r.done_res  = done;
    r.read_byte = last_rd;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing.idle_high_ticks    = IdleHighRst;
      timing.reset_low_ticks    = ResetLowRst;
      timing.reset_wait_ticks   = ResetWaitRst;
      timing.slot_ticks         = SlotRst;
      timing.lead_low_ticks     = LeadLowRst;
      timing.sample_delay_ticks = SampleDlyRst;
      ph           = PhIdle;
      tick_cnt     = '0;
      bit_idx      = 0;
      shreg        = '0;
      drv          = 1'b0;
      op           = FuncTick;
      last_rd      = '0;
      done         = 1'b0;
      mismatches_o = 0;
      pending_o    = 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegIdleHigh:  timing.idle_high_ticks    = pwdata[7:0];
          RegResetLow:  timing.reset_low_ticks    = pwdata[9:0];
          RegResetWait: timing.reset_wait_ticks   = pwdata[9:0];
          RegSlot:      timing.slot_ticks         = pwdata[7:0];
          RegLeadLow:   timing.lead_low_ticks     = pwdata[3:0];
          RegSampleDly: timing.sample_delay_ticks = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected result word: drive %b busy %b done %b byte %h",
                     out_data_i.drive_low, out_data_i.busy_res,
                     out_data_i.done_res, out_data_i.read_byte);
        end else begin
          want = expected_words.pop_front();
          bad  = (out_data_i.drive_low !== want.drive_low) ||
                 (out_data_i.busy_res  !== want.busy_res)  ||
                 (out_data_i.done_res  !== want.done_res)  ||
                 (out_data_i.read_byte !== want.read_byte);
          if (bad) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("mismatch at %0t: expected drive %b busy %b done %b byte %h, got drive %b busy %b done %b byte %h",
                       $realtime, want.drive_low, want.busy_res, want.done_res,
                       want.read_byte, out_data_i.drive_low, out_data_i.busy_res,
                       out_data_i.done_res, out_data_i.read_byte);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_words.push_back(predict_bus(in_data_i));
      pending_o = expected_words.size();
    end
  end

endmodule

### tb/sv/one_wire_bus_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// drives command and tick words into the single-wire master under several
// timing settings and idling patterns; a checker beside the block predicts
// and compares every result word, this module only drives and decides
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;
  import owm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StuckLimit = 4000;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  item_t            in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  res_t             out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int   mismatches;
  int   pending;
  logic owm_busy;
  int   taken;
  int   stuck;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  one_wire_bus_master DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  one_wire_bus_master_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .busy_o       (owm_busy)
  );

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken <= 0;
      stuck <= 0;
    end else begin
      if (in_valid && !in_stall) taken <= taken + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
      else stuck <= stuck + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (stuck < StuckLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_word(logic [1:0] f, logic [7:0] d, logic l);
    int want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.func       <= f;
    in_data.data_byte  <= d;
    in_data.line_level <= l;
    want = taken + 1;
    do @(negedge clk_i); while (taken != want);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_timing(cfg_t c);
    write_reg(RegIdleHigh,  DataW'(c.idle_high_ticks));
    write_reg(RegResetLow,  DataW'(c.reset_low_ticks));
    write_reg(RegResetWait, DataW'(c.reset_wait_ticks));
    write_reg(RegSlot,      DataW'(c.slot_ticks));
    write_reg(RegLeadLow,   DataW'(c.lead_low_ticks));
    write_reg(RegSampleDly, DataW'(c.sample_delay_ticks));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 79; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 79; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  // commands on an idle master followed by ticks, with stray commands mixed in;
  // an operation may still be running when the words run out
  task automatic drive_traffic(int n_words);
    logic [1:0] cmds[3];
    logic [1:0] f;
    cmds = '{FuncReset, FuncWrite, FuncRead};
    for (int i = 0; i < n_words; i++) begin
      if (!owm_busy) f = ($urandom_range(99) < 15) ? FuncTick : cmds[$urandom_range(2)];
      else f = ($urandom_range(99) < 6) ? cmds[$urandom_range(2)] : FuncTick;
      push_word(f, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset-value timing
    set_idling(0);
    drive_traffic(2);
    quiesce();

    // shortest legal timing, zero idle time and zero sample delay
    c = '{idle_high_ticks: 8'd0, reset_low_ticks: 10'd1, reset_wait_ticks: 10'd1,
          slot_ticks: 8'd1, lead_low_ticks: 4'd1, sample_delay_ticks: 4'd0};
    set_timing(c);
    push_word(FuncTick, 8'hff, 1'b0);
    push_word(FuncReset, 8'h00, 1'b1);
    push_word(FuncRead, 8'hff, 1'b1);
    push_word(FuncTick, 8'h00, 1'b0);
    push_word(FuncTick, 8'h00, 1'b1);
    push_word(FuncWrite, 8'hff, 1'b0);
    for (int i = 0; i < 16; i++) push_word(FuncTick, 8'h00, i[0]);
    push_word(FuncRead, 8'h00, 1'b1);
    for (int i = 0; i < 16; i++) push_word(FuncTick, 8'hff, i[1]);
    quiesce();

    for (int p = 0; p < 8; p++) begin
      c.idle_high_ticks = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(3));
      c.reset_low_ticks = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1))
                                                   : 10'($urandom_range(4, 1));
      c.reset_wait_ticks = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 1))
                                                    : 10'($urandom_range(4, 1));
      c.slot_ticks = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1))
                                              : 8'($urandom_range(3, 1));
      c.lead_low_ticks = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 1))
                                                  : 4'($urandom_range(2, 1));
      c.sample_delay_ticks = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(2));
      set_timing(c);
      set_idling(p);
      drive_traffic(95);
      quiesce();
    end

    // longest timing on every register
    c = '{idle_high_ticks: 8'd255, reset_low_ticks: 10'd1023, reset_wait_ticks: 10'd1023,
          slot_ticks: 8'd255, lead_low_ticks: 4'd15, sample_delay_ticks: 4'd15};
    set_timing(c);
    set_idling(0);
    drive_traffic(3);
    quiesce();

    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### one_wire_bus_master.f
hdl/owm_pkg.sv
hdl/owm_regs.sv
hdl/owm_core.sv
hdl/one_wire_bus_master.sv
tb/sv/one_wire_bus_master_checker.sv
tb/sv/one_wire_bus_master_tb.sv
